// ===== src/ptc_pkg.sv =====
// shared types and constants of the pwm thrust converter
package ptc_pkg;

  localparam int FullSpanDef  = 6400;
  localparam int RatioBitsDef = 16;

  localparam int PulseW = 16;
  localparam int ForceW = 21;
  localparam int DbW    = 13;
  localparam int LimW   = 20;
  localparam int AddrW  = 2;

  localparam logic [AddrW-1:0] RegNeutral  = 2'd0;
  localparam logic [AddrW-1:0] RegDeadband = 2'd1;
  localparam logic [AddrW-1:0] RegForward  = 2'd2;
  localparam logic [AddrW-1:0] RegReverse  = 2'd3;

  typedef struct packed {
    logic [PulseW-1:0] neutral;
    logic [DbW-1:0]    deadband;
    logic [LimW-1:0]   fwd_limit;
    logic [LimW-1:0]   rev_limit;
  } ptc_cfg_t;

  // per item flags that travel with the data
  typedef struct packed {
    logic cmd;
    logic neg;
    logic dead;
    logic sat;
    logic one;
  } ptc_side_t;

endpackage

// ===== src/pwm_thrust_converter.sv =====
// top level of the pwm thrust converter
//
// Input stream: s_axis_tdata carries pulse_in and force_in, s_axis_tuser
// carries cmd (0: pulse to thrust, 1: thrust to pulse). Each accepted
// transaction gives exactly one result transaction on the m_axis side
// with force_out, pulse_out, in_deadband and saturated.
// Configuration: cfg_valid_i with cfg_addr_i and cfg_data_i writes one
// register (neutral, deadband, forward limit, reverse limit); always ready.
// Write it only while no transaction is in flight.
// The pipeline has one input stage, a row of 2*RATIO_BITS+2 division
// cells, a row of RATIO_BITS+1 square root cells and three output stages.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls with a result waiting, the whole row of cells
// holds and s_axis_tready falls in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the register defaults.
module pwm_thrust_converter import ptc_pkg::*; #(
  parameter int FULL_SPAN  = FullSpanDef,
  parameter int RATIO_BITS = RatioBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [39:0]      s_axis_tdata,  // pulse_in[15:0], force_in[36:16], zero pad
  input  logic             s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // force_out[20:0], pulse_out[36:21],
                                          // in_deadband[37], saturated[38], zero pad
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [AddrW-1:0] cfg_addr_i,
  input  logic [LimW-1:0]  cfg_data_i
);

  localparam int R      = RATIO_BITS;
  localparam int QW     = 2 * R + 2;
  localparam int RW     = R + 4;
  localparam int SPAN_W = $clog2(FULL_SPAN + 1);

  ptc_cfg_t cfg_q;
  logic     adv;

  logic            dv   [0:QW];
  ptc_side_t       dside[0:QW];
  logic [LimW-1:0] drem [0:QW];
  logic [LimW-1:0] ddiv [0:QW];
  logic [QW-1:0]   dquot[0:QW];

  logic            sv   [0:R+1];
  ptc_side_t       sside[0:R+1];
  logic [QW-1:0]   srad [0:R+1];
  logic [R:0]      sroot[0:R+1];
  logic [RW-1:0]   srem [0:R+1];

  logic [ForceW-1:0] force_out;
  logic [PulseW-1:0] pulse_out;
  logic              dead_out, sat_out;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.neutral   <= PulseW'(24000);
      cfg_q.deadband  <= DbW'(400);
      cfg_q.fwd_limit <= LimW'(40000);
      cfg_q.rev_limit <= LimW'(30000);
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        RegNeutral:  cfg_q.neutral   <= cfg_data_i[PulseW-1:0];
        RegDeadband: cfg_q.deadband  <= cfg_data_i[DbW-1:0];
        RegForward:  cfg_q.fwd_limit <= cfg_data_i;
        RegReverse:  cfg_q.rev_limit <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ptc_front #(.FULL_SPAN(FULL_SPAN), .SPAN_W(SPAN_W)) u_front (
    .clk_i, .rst_ni,
    .en_i    (adv),
    .valid_i (s_axis_tvalid),
    .cmd_i   (s_axis_tuser),
    .pulse_i (s_axis_tdata[15:0]),
    .force_i (s_axis_tdata[36:16]),
    .cfg_i   (cfg_q),
    .valid_o (dv[0]),
    .side_o  (dside[0]),
    .rem_o   (drem[0]),
    .div_o   (ddiv[0])
  );
  assign dquot[0] = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    ptc_div_cell #(.QW(QW)) u_cell (
      .clk_i, .rst_ni,
      .en_i    (adv),
      .valid_i (dv[i]),
      .side_i  (dside[i]),
      .rem_i   (drem[i]),
      .div_i   (ddiv[i]),
      .quot_i  (dquot[i]),
      .valid_o (dv[i+1]),
      .side_o  (dside[i+1]),
      .rem_o   (drem[i+1]),
      .div_o   (ddiv[i+1]),
      .quot_o  (dquot[i+1])
    );
  end

  assign sv[0]    = dv[QW];
  assign sside[0] = dside[QW];
  assign srad[0]  = dquot[QW];
  assign sroot[0] = dside[QW].cmd ? '0 : dquot[QW][QW-1:R+1];
  assign srem[0]  = '0;

  for (genvar j = 0; j <= R; j++) begin : g_sqrt
    ptc_sqrt_cell #(.RATIO_BITS(R)) u_cell (
      .clk_i, .rst_ni,
      .en_i    (adv),
      .valid_i (sv[j]),
      .side_i  (sside[j]),
      .rad_i   (srad[j]),
      .root_i  (sroot[j]),
      .rem_i   (srem[j]),
      .valid_o (sv[j+1]),
      .side_o  (sside[j+1]),
      .rad_o   (srad[j+1]),
      .root_o  (sroot[j+1]),
      .rem_o   (srem[j+1])
    );
  end

  ptc_back #(.FULL_SPAN(FULL_SPAN), .RATIO_BITS(R), .SPAN_W(SPAN_W)) u_back (
    .clk_i, .rst_ni,
    .en_i    (adv),
    .valid_i (sv[R+1]),
    .side_i  (sside[R+1]),
    .root_i  (sroot[R+1]),
    .cfg_i   (cfg_q),
    .valid_o (m_axis_tvalid),
    .force_o (force_out),
    .pulse_o (pulse_out),
    .dead_o  (dead_out),
    .sat_o   (sat_out)
  );

  assign m_axis_tdata = {1'b0, sat_out, dead_out, pulse_out, force_out};

  a_dead_no_force: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[37] |-> m_axis_tdata[20:0] == '0)
    else $error("deadband result carries thrust");

  a_one_direction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[20:0] == '0 || m_axis_tdata[36:21] == '0)
    else $error("thrust and pulse both nonzero");

  a_dead_not_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[37] && m_axis_tdata[38]))
    else $error("deadband and saturation together");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(dv[0]) && $stable(sv[0]))
    else $error("cell row moved during stall");

endmodule

// ===== src/ptc_front.sv =====
// input stage: distance from neutral, clamp and divider operands
module ptc_front import ptc_pkg::*; #(
  parameter int FULL_SPAN = FullSpanDef,
  parameter int SPAN_W    = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic              cmd_i,
  input  logic [PulseW-1:0] pulse_i,
  input  logic [ForceW-1:0] force_i,
  input  ptc_cfg_t          cfg_i,
  output logic              valid_o,
  output ptc_side_t         side_o,
  output logic [LimW-1:0]   rem_o,
  output logic [LimW-1:0]   div_o
);

  localparam logic [SPAN_W-1:0] SpanC = SPAN_W'(FULL_SPAN);

  logic              valid_q;
  ptc_side_t         side_q, side_d;
  logic [LimW-1:0]   rem_q, rem_d, div_q, div_d;
  logic              pos;
  logic [PulseW-1:0] delta, exc;
  logic [SPAN_W-1:0] span;
  logic [ForceW-1:0] fmag;
  logic [LimW-1:0]   lim, clamped;

  always_comb begin
    pos   = pulse_i > cfg_i.neutral;
    delta = pos ? pulse_i - cfg_i.neutral : cfg_i.neutral - pulse_i;
    exc   = delta - PulseW'(cfg_i.deadband);
    span = (SPAN_W'(cfg_i.deadband) < SpanC && {{(SPAN_W){1'b0}}, cfg_i.deadband} <
            {{(DbW){1'b0}}, SpanC}) ? SpanC - SPAN_W'(cfg_i.deadband) : '0;
    fmag = force_i[ForceW-1] ? ForceW'(0) - force_i : force_i;
    lim  = force_i[ForceW-1] ? cfg_i.rev_limit : cfg_i.fwd_limit;
    clamped = (fmag > ForceW'(lim)) ? lim : fmag[LimW-1:0];
    side_d = '0;
    side_d.cmd = cmd_i;
    rem_d = '0;
    div_d = '0;
    if (!cmd_i) begin
      side_d.neg  = !pos;
      side_d.dead = delta <= PulseW'(cfg_i.deadband);
      side_d.one  = !side_d.dead && (span == '0 || LimW'(exc) >= LimW'(span));
      side_d.sat  = !side_d.dead && (span == '0 || LimW'(exc) > LimW'(span));
      div_d = LimW'(span);
      rem_d = side_d.one ? '0 : LimW'(exc);
    end else begin
      side_d.neg  = force_i[ForceW-1];
      side_d.dead = fmag == '0;
      side_d.sat  = !side_d.dead && fmag > ForceW'(lim);
      side_d.one  = !side_d.dead && (lim == '0 || clamped == lim);
      div_d = lim;
      rem_d = (side_d.one || side_d.dead) ? '0 : clamped;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_d;
      rem_q  <= rem_d;
      div_q  <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;

endmodule

// ===== src/ptc_div_cell.sv =====
// one restoring division step, one quotient bit per cell
module ptc_div_cell import ptc_pkg::*; #(
  parameter int QW = 34
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  ptc_side_t       side_i,
  input  logic [LimW-1:0] rem_i,
  input  logic [LimW-1:0] div_i,
  input  logic [QW-1:0]   quot_i,
  output logic            valid_o,
  output ptc_side_t       side_o,
  output logic [LimW-1:0] rem_o,
  output logic [LimW-1:0] div_o,
  output logic [QW-1:0]   quot_o
);

  logic            valid_q;
  ptc_side_t       side_q;
  logic [LimW-1:0] rem_q, rem_d, div_q;
  logic [QW-1:0]   quot_q, quot_d;
  logic [LimW:0]   rem2, diff;
  logic            ge;

  always_comb begin
    rem2   = {rem_i, 1'b0};
    diff   = rem2 - {1'b0, div_i};
    ge     = rem2 >= {1'b0, div_i};
    rem_d  = ge ? diff[LimW-1:0] : rem2[LimW-1:0];
    quot_d = {quot_i[QW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem_d;
      div_q  <= div_i;
      quot_q <= quot_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign div_o   = div_q;
  assign quot_o  = quot_q;

endmodule

// ===== src/ptc_sqrt_cell.sv =====
// one digit of the integer square root, two radicand bits per cell
module ptc_sqrt_cell import ptc_pkg::*; #(
  parameter int RATIO_BITS = RatioBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  ptc_side_t           side_i,
  input  logic [2*RATIO_BITS+1:0] rad_i,
  input  logic [RATIO_BITS:0]     root_i,
  input  logic [RATIO_BITS+3:0]   rem_i,
  output logic                valid_o,
  output ptc_side_t           side_o,
  output logic [2*RATIO_BITS+1:0] rad_o,
  output logic [RATIO_BITS:0]     root_o,
  output logic [RATIO_BITS+3:0]   rem_o
);

  localparam int QW = 2 * RATIO_BITS + 2;
  localparam int RW = RATIO_BITS + 4;

  logic            valid_q;
  ptc_side_t       side_q;
  logic [QW-1:0]   rad_q;
  logic [RATIO_BITS:0] root_q, root_d;
  logic [RW-1:0]   rem_q, rem_d, rem2, trial;
  logic            ge, act;

  always_comb begin
    act    = side_i.cmd && !side_i.one && !side_i.dead;
    rem2   = {rem_i[RW-3:0], rad_i[QW-1:QW-2]};
    trial  = {1'b0, root_i, 2'b01};
    ge     = rem2 >= trial;
    rem_d  = rem_i;
    root_d = root_i;
    if (act) begin
      rem_d  = ge ? rem2 - trial : rem2;
      root_d = {root_i[RATIO_BITS-1:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rad_q  <= {rad_i[QW-3:0], 2'b00};
      root_q <= root_d;
      rem_q  <= rem_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rad_o   = rad_q;
  assign root_o  = root_q;
  assign rem_o   = rem_q;

endmodule

// ===== src/ptc_back.sv =====
// output stages: squaring or span scaling, limit scaling, pulse clamp
module ptc_back import ptc_pkg::*; #(
  parameter int FULL_SPAN  = FullSpanDef,
  parameter int RATIO_BITS = RatioBitsDef,
  parameter int SPAN_W     = 15
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ptc_side_t            side_i,
  input  logic [RATIO_BITS:0]  root_i,
  input  ptc_cfg_t             cfg_i,
  output logic                 valid_o,
  output logic [ForceW-1:0]    force_o,
  output logic [PulseW-1:0]    pulse_o,
  output logic                 dead_o,
  output logic                 sat_o
);

  localparam int R  = RATIO_BITS;
  localparam int MB = (R + 1 > SPAN_W) ? R + 1 : SPAN_W;
  localparam int P1 = R + 1 + MB;
  localparam int P2 = LimW + R + 1;
  localparam logic [R:0]  OneQ   = (R+1)'(1) << R;
  localparam logic [P1:0] HalfP1 = (P1+1)'(1) << (R - 1);
  localparam logic [P2:0] HalfP2 = (P2+1)'(1) << (R - 1);
  localparam logic [SPAN_W-1:0] SpanC = SPAN_W'(FULL_SPAN);

  logic              v1_q, v2_q, v3_q;
  ptc_side_t         s1_q, s2_q, s2_d;
  logic [P1-1:0]     prod1_q;
  logic [P2-1:0]     prod2_q;
  logic [PulseW-1:0] pulse2_q, pulse2_d, pulse3_q;
  logic [ForceW-1:0] force3_q, force3_d;
  logic              dead3_q, sat3_q;

  logic [R+1:0]      rp1;
  logic [R:0]        ratio;
  logic [MB-1:0]     mul_b;
  logic [SPAN_W-1:0] span;
  logic [P1:0]       rnd1;
  logic [R:0]        sq;
  logic [LimW-1:0]   lim2;
  logic [PulseW+1:0] offs, psum;
  logic [P2:0]       rnd2;
  logic [ForceW-1:0] mag;

  always_comb begin
    rp1   = {1'b0, root_i} + (R+2)'(1);
    ratio = side_i.one ? OneQ : rp1[R+1:1];
    span  = ({{(SPAN_W){1'b0}}, cfg_i.deadband} < {{(DbW){1'b0}}, SpanC}) ?
            SpanC - SPAN_W'(cfg_i.deadband) : '0;
    mul_b = side_i.cmd ? MB'(span) : MB'(ratio);
  end

  always_comb begin
    rnd1 = {1'b0, prod1_q} + HalfP1;
    sq   = rnd1[2*R:R];
    lim2 = s1_q.neg ? cfg_i.rev_limit : cfg_i.fwd_limit;
    offs = (PulseW+2)'(cfg_i.deadband) + (PulseW+2)'(rnd1[P1:R]);
    psum = (PulseW+2)'(cfg_i.neutral) + offs;
    s2_d = s1_q;
    pulse2_d = '0;
    if (s1_q.cmd) begin
      if (s1_q.dead) begin
        pulse2_d = cfg_i.neutral;
      end else if (!s1_q.neg) begin
        if (psum > (PulseW+2)'({PulseW{1'b1}})) begin
          pulse2_d = '1;
          s2_d.sat = 1'b1;
        end else begin
          pulse2_d = psum[PulseW-1:0];
        end
      end else if (offs > (PulseW+2)'(cfg_i.neutral)) begin
        s2_d.sat = 1'b1;
      end else begin
        pulse2_d = cfg_i.neutral - offs[PulseW-1:0];
      end
    end
  end

  always_comb begin
    rnd2 = {1'b0, prod2_q} + HalfP2;
    mag  = ForceW'(rnd2[P2:R]);
    force3_d = '0;
    if (!s2_q.cmd && !s2_q.dead) begin
      force3_d = s2_q.neg ? ForceW'(0) - mag : mag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q     <= side_i;
      prod1_q  <= P1'(ratio * mul_b);
      s2_q     <= s2_d;
      prod2_q  <= P2'(lim2 * sq);
      pulse2_q <= pulse2_d;
      force3_q <= force3_d;
      pulse3_q <= pulse2_q;
      dead3_q  <= s2_q.dead;
      sat3_q   <= s2_q.sat;
    end
  end

  assign valid_o = v3_q;
  assign force_o = force3_q;
  assign pulse_o = pulse3_q;
  assign dead_o  = dead3_q;
  assign sat_o   = sat3_q;

endmodule

// ===== dv/pwm_thrust_converter_tb.sv =====
// testbench of the pwm thrust converter: directed and random conversions checked against a predictor
`timescale 1ns / 1ps

module pwm_thrust_converter_tb;
  import ptc_pkg::*;

  localparam int FullSpan  = FullSpanDef;
  localparam int RatioBits = RatioBitsDef;
  localparam int Latency   = 3 * RatioBits + 7;
  localparam int Limit     = 20000;

  typedef struct packed {
    logic              sat;
    logic              dead;
    logic [PulseW-1:0] pulse;
    logic [ForceW-1:0] force_v;
  } conv_res_t;

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [39:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic cfg_valid_i, cfg_ready_o;
  logic [AddrW-1:0] cfg_addr_i;
  logic [LimW-1:0] cfg_data_i;

  logic [15:0] neutral_q;
  logic [12:0] deadband_q;
  logic [19:0] fwd_q, rev_q;
  conv_res_t results_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit long_stalls;

  pwm_thrust_converter u_dut (.*);

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, b;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      b = root | (64'd1 << i);
      if (b * b <= x) root = b;
    end
    return root;
  endfunction

  function automatic conv_res_t convert(logic cmd, logic [15:0] pulse, logic [20:0] force_v);
    conv_res_t res;
    longint unsigned span, d, e, r, sq, mag, lim, c, q, off, p;
    bit pos, neg;
    res = '0;
    span = (deadband_q < FullSpan) ? FullSpan - deadband_q : 0;
    if (!cmd) begin
      pos = pulse > neutral_q;
      d = pos ? pulse - neutral_q : neutral_q - pulse;
      if (d <= deadband_q) begin
        res.dead = 1'b1;
      end else begin
        e = d - deadband_q;
        lim = pos ? fwd_q : rev_q;
        if (span == 0 || e >= span) begin
          r = 64'd1 << RatioBits;
          if (span == 0 || e > span) res.sat = 1'b1;
        end else begin
          r = ((e << (RatioBits + 1)) + span) / (2 * span);
        end
        sq = (r * r + (64'd1 << (RatioBits - 1))) >> RatioBits;
        mag = (lim * sq + (64'd1 << (RatioBits - 1))) >> RatioBits;
        res.force_v = pos ? 21'(mag) : 21'(-mag);
      end
    end else begin
      neg = force_v[20];
      mag = neg ? 64'(-$signed(force_v)) : 64'(force_v);
      if (mag == 0) begin
        res.dead = 1'b1;
        res.pulse = neutral_q;
      end else begin
        lim = neg ? rev_q : fwd_q;
        c = mag;
        if (c > lim) begin
          c = lim;
          res.sat = 1'b1;
        end
        if (lim == 0) r = 64'd1 << RatioBits;
        else begin
          q = (c << (2 * RatioBits + 2)) / lim;
          r = (int_sqrt(q) + 1) >> 1;
        end
        off = deadband_q + ((r * span + (64'd1 << (RatioBits - 1))) >> RatioBits);
        if (!neg) begin
          p = neutral_q + off;
          if (p > 16'hFFFF) begin
            p = 16'hFFFF;
            res.sat = 1'b1;
          end
          res.pulse = p[15:0];
        end else if (off > neutral_q) begin
          res.sat = 1'b1;
        end else begin
          res.pulse = 16'(neutral_q - off);
        end
      end
    end
    return res;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(99) < 3) return $urandom_range(40, 10);
    if ($urandom_range(99) < 40) return $urandom_range(3, 1);
    return 0;
  endfunction

  task automatic send_item(logic cmd, logic [15:0] pulse, logic [20:0] force_v);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {3'b0, force_v, pulse};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    results_q.push_back(convert(cmd, pulse, force_v));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (results_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [AddrW-1:0] addr, logic [LimW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (addr)
      RegNeutral:  neutral_q = data[15:0];
      RegDeadband: deadband_q = data[12:0];
      RegForward:  fwd_q = data;
      default:     rev_q = data;
    endcase
  endtask

  task automatic set_config(logic [15:0] n, logic [12:0] db, logic [19:0] f, logic [19:0] r);
    write_reg(RegNeutral, n);
    write_reg(RegDeadband, db);
    write_reg(RegForward, f);
    write_reg(RegReverse, r);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(1'b0, neutral_q, 21'd0);
    send_item(1'b0, neutral_q + deadband_q, 21'd0);
    send_item(1'b0, neutral_q + deadband_q + 16'd1, 21'd0);
    send_item(1'b0, neutral_q - deadband_q - 16'd1, 21'd0);
    send_item(1'b0, neutral_q + 16'd6400, 21'd0);
    send_item(1'b0, 16'hFFFF, 21'h1FFFFF);
    send_item(1'b0, 16'h0000, 21'h1FFFFF);
    send_item(1'b1, 16'hFFFF, 21'd0);
    send_item(1'b1, 16'h0, 21'd1);
    send_item(1'b1, 16'h0, -21'sd1);
    send_item(1'b1, 16'h0, 21'(fwd_q));
    send_item(1'b1, 16'h0, 21'(fwd_q) + 21'd1);
    send_item(1'b1, 16'h0, -21'(rev_q));
    send_item(1'b1, 16'h0, 21'd1000000);
    send_item(1'b1, 16'h0, -21'sd1000000);
    send_item(1'b1, 16'h0, 21'h100000);
    send_item(1'b1, 16'hFFFF, 21'h0FFFFF);
    drain();
  endtask

  task automatic test_random(int n);
    logic cmd;
    logic [15:0] pulse;
    logic [20:0] force_v;
    int span;
    for (int i = 0; i < n; i++) begin
      cmd = 1'($urandom_range(1));
      span = deadband_q + FullSpan + 200;
      case ($urandom_range(3))
        0: pulse = 16'($urandom);
        default: pulse = neutral_q + 16'($urandom_range(2 * span) - span);
      endcase
      case ($urandom_range(3))
        0: force_v = 21'($urandom);
        1: force_v = 21'($signed($urandom_range(2000000)) - 1000000);
        2: force_v = 21'($signed($urandom_range(2 * fwd_q + 2)) - fwd_q - 1);
        default: force_v = 21'($signed($urandom_range(200)) - 100);
      endcase
      send_item(cmd, pulse, force_v);
    end
    drain();
  endtask

  task automatic test_extreme_config();
    set_config(16'd0, 13'd0, 20'd1, 20'd1);
    test_random(40);
    set_config(16'hFFFF, 13'd6383, 20'd1000000, 20'd1000000);
    test_random(40);
    set_config(16'd100, 13'd6400, 20'd5000, 20'd7000);
    test_directed();
    test_random(30);
    set_config(16'd30000, 13'h1FFF, 20'd0, 20'd0);
    test_directed();
    test_random(30);
  endtask

  always @(posedge clk_i) begin
    conv_res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = conv_res_t'(m_axis_tdata[38:0]);
        if (results_q.size() == 0) begin
          $display("%0t: result with none expected: %h", $time, got);
          errors++;
        end else begin
          want = results_q.pop_front();
          if (got.force_v !== want.force_v) begin
            $display("%0t: force_out exp %h got %h", $time, want.force_v, got.force_v);
            errors++;
          end
          if (got.pulse !== want.pulse) begin
            $display("%0t: pulse_out exp %h got %h", $time, want.pulse, got.pulse);
            errors++;
          end
          if (got.dead !== want.dead) begin
            $display("%0t: in_deadband exp %b got %b", $time, want.dead, got.dead);
            errors++;
          end
          if (got.sat !== want.sat) begin
            $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
            errors++;
          end
        end
      end
      if (long_stalls) m_axis_tready <= ($urandom_range(9) < 3);
      else m_axis_tready <= ($urandom_range(9) != 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_valid_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= Limit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    long_stalls = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = 1'b0;
    s_axis_tdata = '0;
    cfg_valid_i = 1'b0;
    cfg_addr_i = '0;
    cfg_data_i = '0;
    neutral_q = 16'd24000;
    deadband_q = 13'd400;
    fwd_q = 20'd40000;
    rev_q = 20'd30000;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    long_stalls = 1;
    test_random(100);
    long_stalls = 0;
    test_extreme_config();
    set_config(16'd24000, 13'd1000, 20'd123457, 20'd65432);
    test_random(100);
    if (errors == 0 && results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
